// ===== rtl/core/wcnt_pkg.sv =====
// shared types, constants and character class functions for the text counter
package wcnt_pkg;

  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned OUT_BITS    = 32;
  localparam int unsigned POINT_BITS  = 21;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_CR      = 8'h0D;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef enum logic [1:0] {
    KIND_JUDGE = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_LEAD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       ws;
    logic       nl;
    logic       chr;
    logic       last;
    logic [1:0] tail;
    logic [5:0] bits;
  } item_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OUT_BITS-1:0]   total_t;

  function automatic logic ascii_space(input logic [7:0] b);
    return (b == BYTE_SPACE) || ((b >= BYTE_TAB) && (b <= BYTE_CR));
  endfunction

  function automatic logic unicode_space(input logic [POINT_BITS-1:0] c);
    logic hit;
    hit = (c == POINT_BITS'(BYTE_SPACE)) ||
          ((c >= POINT_BITS'(BYTE_TAB)) && (c <= POINT_BITS'(BYTE_CR)));
    hit = hit || ((c >= POINT_BITS'(21'h2000)) && (c <= POINT_BITS'(21'h200A)));
    hit = hit || (c == POINT_BITS'(21'h0085)) || (c == POINT_BITS'(21'h00A0)) ||
          (c == POINT_BITS'(21'h1680)) || (c == POINT_BITS'(21'h2028)) ||
          (c == POINT_BITS'(21'h2029)) || (c == POINT_BITS'(21'h202F)) ||
          (c == POINT_BITS'(21'h205F)) || (c == POINT_BITS'(21'h3000));
    return hit;
  endfunction

  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  function automatic total_t show(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'({OUT_BITS{1'b1}})) ? '1 : w[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/utf8_line_word_char_counter.sv =====
// top level of the line, word, character and byte counter
// Takes one byte per cycle: the front stage classifies each byte in the cycle it is
// accepted and writes it to a two-entry queue; the back stage retires one queued byte
// per cycle into saturating counters, unless a last byte waits on a held result. It
// registers a file's totals when it retires the last byte; the next file's bytes are taken
// meanwhile; only a held result with a further last byte behind it stalls the input.
// text_mode resets to 1 (UTF-8); users write text_mode_we_i only while idle (unenforced).
module utf8_line_word_char_counter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              text_mode_we_i,
  input  logic              text_mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_value_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wcnt_pkg::total_t  line_total_o,
  output wcnt_pkg::total_t  word_total_o,
  output wcnt_pkg::total_t  char_total_o,
  output wcnt_pkg::total_t  byte_total_o
);
  import wcnt_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  logic  push;

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && !queue_full;

  wcnt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_mode_we_i (text_mode_we_i),
    .text_mode_i    (text_mode_i),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .item_o         (front_item)
  );

  wcnt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .data_o      (queue_item)
  );

  wcnt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (queue_valid),
    .ent_i        (queue_item),
    .pop_o        (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_total_o (line_total_o),
    .word_total_o (word_total_o),
    .char_total_o (char_total_o),
    .byte_total_o (byte_total_o)
  );

endmodule

// ===== rtl/core/wcnt_front.sv =====
// front stage: mode register and per-byte classification
module wcnt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           text_mode_we_i,
  input  logic           text_mode_i,
  input  logic [7:0]     byte_value_i,
  input  logic           last_byte_i,
  output wcnt_pkg::item_t item_o
);
  import wcnt_pkg::*;

  logic text_mode_q;
  logic is_cont;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b1;
    end else if (text_mode_we_i) begin
      text_mode_q <= text_mode_i;
    end
  end

  assign is_cont = (byte_value_i[7:6] == CONT_TAG);

  always_comb begin
    item_o      = '0;
    item_o.kind = KIND_JUDGE;
    item_o.nl   = (byte_value_i == BYTE_NEWLINE);
    item_o.chr  = !text_mode_q || !is_cont;
    item_o.last = last_byte_i;
    if (!text_mode_q || !byte_value_i[7]) begin
      item_o.ws = ascii_space(byte_value_i);
    end else if (is_cont) begin
      item_o.kind = KIND_CONT;
      item_o.bits = byte_value_i[5:0];
    end else if (byte_value_i[7:5] == LEAD2_TAG) begin
      item_o.kind = KIND_LEAD;
      item_o.tail = 2'd1;
      item_o.bits = {1'b0, byte_value_i[4:0]};
    end else if (byte_value_i[7:4] == LEAD3_TAG) begin
      item_o.kind = KIND_LEAD;
      item_o.tail = 2'd2;
      item_o.bits = {2'b0, byte_value_i[3:0]};
    end else if (byte_value_i[7:3] == LEAD4_TAG) begin
      item_o.kind = KIND_LEAD;
      item_o.tail = 2'd3;
      item_o.bits = {3'b0, byte_value_i[2:0]};
    end
  end

endmodule

// ===== rtl/core/wcnt_queue.sv =====
// short queue of classified bytes between front and back
module wcnt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wcnt_pkg::item_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wcnt_pkg::item_t data_o
);
  import wcnt_pkg::*;

  item_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QUEUE_CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/wcnt_back.sv =====
// back stage: sequence decoding, word tracking, saturating counters, result register
module wcnt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ent_valid_i,
  input  wcnt_pkg::item_t      ent_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wcnt_pkg::total_t     line_total_o,
  output wcnt_pkg::total_t     word_total_o,
  output wcnt_pkg::total_t     char_total_o,
  output wcnt_pkg::total_t     byte_total_o
);
  import wcnt_pkg::*;

  logic                   after_space_q, after_space_d;
  logic [POINT_BITS-1:0]  partial_q, partial_d;
  logic [1:0]             tail_q, tail_d;
  count_t                 lines_q, lines_d;
  count_t                 words_q, words_d;
  count_t                 chars_q, chars_d;
  count_t                 bytes_q, bytes_d;
  logic                   out_valid_q;
  total_t                 line_out_q, word_out_q, char_out_q, byte_out_q;
  logic                   judge_en;
  logic                   judge_ws;
  logic                   finish;

  // a last byte needs the result register free
  assign pop_o  = ent_valid_i && (!ent_i.last || !out_valid_q || out_ready_i);
  assign finish = pop_o && ent_i.last;

  always_comb begin
    partial_d = partial_q;
    tail_d    = tail_q;
    judge_en  = 1'b0;
    judge_ws  = 1'b0;
    case (ent_i.kind)
      KIND_JUDGE: begin
        partial_d = '0;
        tail_d    = '0;
        judge_en  = 1'b1;
        judge_ws  = ent_i.ws;
      end
      KIND_CONT: begin
        if (tail_q == '0) begin
          judge_en = 1'b1;
        end else begin
          partial_d = {partial_q[POINT_BITS-7:0], ent_i.bits};
          tail_d    = tail_q - 2'd1;
          if (tail_q == 2'd1) begin
            judge_en  = 1'b1;
            judge_ws  = unicode_space(partial_d);
            partial_d = '0;
          end
        end
      end
      KIND_LEAD: begin
        partial_d = POINT_BITS'(ent_i.bits);
        tail_d    = ent_i.tail;
      end
      default: begin
        partial_d = '0;
        tail_d    = '0;
      end
    endcase

    after_space_d = judge_en ? judge_ws : after_space_q;
    words_d = (judge_en && !judge_ws && after_space_q) ? bump(words_q) : words_q;
    lines_d = ent_i.nl ? bump(lines_q) : lines_q;
    chars_d = ent_i.chr ? bump(chars_q) : chars_q;
    bytes_d = bump(bytes_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_space_q <= 1'b1;
      partial_q     <= '0;
      tail_q        <= '0;
      lines_q       <= '0;
      words_q       <= '0;
      chars_q       <= '0;
      bytes_q       <= '0;
    end else if (finish) begin
      after_space_q <= 1'b1;
      partial_q     <= '0;
      tail_q        <= '0;
      lines_q       <= '0;
      words_q       <= '0;
      chars_q       <= '0;
      bytes_q       <= '0;
    end else if (pop_o) begin
      after_space_q <= after_space_d;
      partial_q     <= partial_d;
      tail_q        <= tail_d;
      lines_q       <= lines_d;
      words_q       <= words_d;
      chars_q       <= chars_d;
      bytes_q       <= bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      line_out_q <= show(lines_d);
      word_out_q <= show(words_d);
      char_out_q <= show(chars_d);
      byte_out_q <= show(bytes_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_total_o = line_out_q;
  assign word_total_o = word_out_q;
  assign char_total_o = char_out_q;
  assign byte_total_o = byte_out_q;

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q && after_space_q && (bytes_q == '0) && (tail_q == '0))
    else $error("file state not cleared after last transfer");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(finish))
    else $error("result raised without a last byte");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !finish)
    else $error("pending result overwritten");

  a_bytes_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> byte_out_q != '0)
    else $error("result with zero bytes");

endmodule
